>>> rtl/lbpc_pkg.sv
// lbpc_pkg: shared types, constants and helpers for the 3x3 lbp code block
// no dependencies; imported by every module under rtl/
package lbpc_pkg;

    // default sizes of the line stores, the frame counters and the queues
    localparam int LBPC_MAX_WIDTH   = 2048;
    localparam int LBPC_MAX_HEIGHT  = 4096;
    localparam int LBPC_QUEUE_DEPTH = 2;

    // register file
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int FW_W       = 12;
    localparam int FH_W       = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BORDER_MODE  = 2'd2;

    localparam logic [FW_W-1:0] RST_FRAME_WIDTH  = 12'd640;
    localparam logic [FH_W-1:0] RST_FRAME_HEIGHT = 13'd480;
    localparam logic            RST_BORDER_MODE  = 1'b0;

    // input item kinds
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    // border fill
    localparam logic BORDER_ZERO      = 1'b0;
    localparam logic BORDER_REPLICATE = 1'b1;

    // one window column, top to bottom
    typedef struct packed {
        logic [7:0] top;
        logic [7:0] mid;
        logic [7:0] bot;
    } t_col;

    // work item handed from the front to the back
    typedef struct packed {
        logic shift;      // push col into the window
        t_col col;
        logic emit;       // a code leaves for this item
        logic lsel;       // left column is border
        logic rpad;       // right column is border (row-end code)
        logic row_end;
        logic frame_end;
    } t_work;

    typedef struct packed {
        logic [7:0] code;
        logic       row_end;
        logic       frame_end;
    } t_result;

    function automatic logic [7:0] pad_px(input logic [7:0] v, input logic mode);
        return (mode == BORDER_REPLICATE) ? v : 8'd0;
    endfunction

    function automatic t_col pad_col(input t_col c, input logic mode);
        t_col p;
        p.top = pad_px(c.top, mode);
        p.mid = pad_px(c.mid, mode);
        p.bot = pad_px(c.bot, mode);
        return p;
    endfunction

endpackage

>>> rtl/lbp_3x3_code.sv
// lbp_3x3_code: streaming 3x3 local binary pattern, one code per pixel in raster order.
// Throughput: one item per clock while full is low, bound by one read and one write of the
// line stores a cycle. Codes pass the front stage, work queue and result queue once the item
// completing the window is taken (one row plus one pixel later; flushes drain the last row).
// Reset (synchronous, i_rst_n low): counters, queues and window clear; registers go to
// 640 x 480, zero border. Line stores are not cleared and need no clearing pass.
module lbp_3x3_code
    import lbpc_pkg::*;
#(
    parameter int MAX_WIDTH   = LBPC_MAX_WIDTH,
    parameter int MAX_HEIGHT  = LBPC_MAX_HEIGHT,
    parameter int QUEUE_DEPTH = LBPC_QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic                  i_action,
    input  logic [7:0]            i_pixel,
    output logic                  empty,
    input  logic                  pop,
    output logic [7:0]            o_lbp_code,
    output logic                  o_row_end,
    output logic                  o_frame_end
);

    t_work   front_work, back_work;
    logic    work_push, work_full, work_pop, work_empty;
    logic    border_mode;
    t_result res_in, res_out;
    logic    res_push, res_full;

    lbpc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .push          (push),
        .full          (full),
        .i_action      (i_action),
        .i_pixel       (i_pixel),
        .o_work        (front_work),
        .o_work_push   (work_push),
        .i_work_full   (work_full),
        .o_border_mode (border_mode)
    );

    lbpc_queue #(
        .WIDTH ($bits(t_work)),
        .DEPTH (QUEUE_DEPTH)
    ) u_work_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (work_push),
        .i_data  (front_work),
        .o_full  (work_full),
        .i_pop   (work_pop),
        .o_data  (back_work),
        .o_empty (work_empty)
    );

    lbpc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_work        (back_work),
        .i_work_valid  (!work_empty),
        .o_work_pop    (work_pop),
        .i_border_mode (border_mode),
        .o_res         (res_in),
        .o_res_push    (res_push),
        .i_res_full    (res_full)
    );

    lbpc_queue #(
        .WIDTH ($bits(t_result)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_lbp_code  = res_out.code;
    assign o_row_end   = res_out.row_end;
    assign o_frame_end = res_out.frame_end;

endmodule

>>> rtl/lbpc_queue.sv
// lbpc_queue: small register queue used between front and back and at the result side
// depends on lbpc_pkg for the default width and depth
module lbpc_queue
    import lbpc_pkg::*;
#(
    parameter int WIDTH = $bits(t_result),
    parameter int DEPTH = LBPC_QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [NW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == NW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + NW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NW'(DEPTH))
        else $error("queue count above depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + NW'(1)))
        else $error("queue count did not grow on push");

    a_pop_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_pop && !do_push && r_count > NW'(1)) |=> !o_empty && $stable(r_wr_ptr))
        else $error("queue lost entries on pop");

endmodule

>>> rtl/lbpc_front.sv
// lbpc_front: config registers, raster counters, line stores and item classification
// depends on lbpc_pkg; feeds lbpc_back through a lbpc_queue
module lbpc_front
    import lbpc_pkg::*;
#(
    parameter int MAX_WIDTH  = LBPC_MAX_WIDTH,
    parameter int MAX_HEIGHT = LBPC_MAX_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic                  i_action,
    input  logic [7:0]            i_pixel,
    output t_work                 o_work,
    output logic                  o_work_push,
    input  logic                  i_work_full,
    output logic                  o_border_mode
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 2);

    function automatic logic [WW-1:0] clamp_w(input logic [FW_W-1:0] v);
        logic [WW-1:0] r;
        if (v == '0) begin
            r = WW'(1);
        end else if (32'(v) > 32'(MAX_WIDTH)) begin
            r = WW'(MAX_WIDTH);
        end else begin
            r = WW'(v);
        end
        return r;
    endfunction

    function automatic logic [HW-1:0] clamp_h(input logic [FH_W-1:0] v);
        logic [HW-1:0] r;
        if (v == '0) begin
            r = HW'(1);
        end else if (32'(v) > 32'(MAX_HEIGHT)) begin
            r = HW'(MAX_HEIGHT);
        end else begin
            r = HW'(v);
        end
        return r;
    endfunction

    // config, held already clamped
    logic [WW-1:0] r_w;
    logic [HW-1:0] r_h;
    logic          r_border_mode;

    // raster position of the next item
    logic [CW-1:0] r_in_col, n_in_col;
    logic [RW-1:0] r_in_row, n_in_row;

    // line stores
    logic [7:0] r_upper_line  [MAX_WIDTH];
    logic [7:0] r_middle_line [MAX_WIDTH];
    logic [7:0] r_rd_up, r_rd_mid;
    logic       r_byp;
    logic [7:0] r_byp_up, r_byp_mid;

    // stage holding an item while its line data comes back
    logic          r_s1_valid;
    logic          r_s1_shift, r_s1_top_pad, r_s1_bot_pad, r_s1_wr;
    logic [CW-1:0] r_s1_idx;
    logic [7:0]    r_s1_pixel;
    logic          r_s1_emit, r_s1_lsel, r_s1_rpad, r_s1_re, r_s1_fe;

    logic          accept, flush, ignore, load, s1_adv, mem_we;
    logic [RW-1:0] h_ext;
    logic [WW-1:0] col_ext, col_inc;
    logic          row_lt_h, row_gt_h, row_ge2, row_is1, col_is0, col_is1;
    logic          end_emit, pix_emit, pix_re;
    logic [7:0]    s1_up, s1_mid;

    assign h_ext    = RW'(r_h);
    assign col_ext  = WW'(r_in_col);
    assign col_inc  = col_ext + WW'(1);
    assign row_lt_h = r_in_row < h_ext;
    assign row_gt_h = r_in_row > h_ext;
    assign row_ge2  = r_in_row >= RW'(2);
    assign row_is1  = r_in_row == RW'(1);
    assign col_is0  = r_in_col == '0;
    assign col_is1  = r_in_col == CW'(1);

    assign flush  = (i_action == ACT_FLUSH);
    assign ignore = flush && row_lt_h;      // flush before the last row has arrived
    assign s1_adv = r_s1_valid && !i_work_full;
    assign full   = r_s1_valid && i_work_full;
    assign accept = push && !full;
    assign load   = accept && !ignore;
    assign mem_we = s1_adv && r_s1_wr;

    // row-end code of the row two above, or pixel code one row and one column back
    assign end_emit = (col_is0 || row_gt_h) && row_ge2;
    assign pix_emit = !row_gt_h && !col_is0 && (r_in_row != '0);
    assign pix_re   = col_ext >= r_w;

    always_comb begin
        n_in_col = r_in_col;
        n_in_row = r_in_row;
        if (load) begin
            if (row_gt_h) begin
                n_in_col = '0;
                n_in_row = '0;
            end else if (col_inc >= r_w) begin
                n_in_col = '0;
                n_in_row = r_in_row + RW'(1);
            end else begin
                n_in_col = CW'(col_inc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w           <= clamp_w(RST_FRAME_WIDTH);
            r_h           <= clamp_h(RST_FRAME_HEIGHT);
            r_border_mode <= RST_BORDER_MODE;
            r_in_col      <= '0;
            r_in_row      <= '0;
            r_s1_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FRAME_WIDTH:  r_w <= clamp_w(i_cfg_data[FW_W-1:0]);
                    CFG_FRAME_HEIGHT: r_h <= clamp_h(i_cfg_data[FH_W-1:0]);
                    CFG_BORDER_MODE:  r_border_mode <= i_cfg_data[0];
                    default: ;
                endcase
            end
            r_in_col <= n_in_col;
            r_in_row <= n_in_row;
            if (load) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_s1_shift   <= !row_gt_h;
            r_s1_top_pad <= row_is1;
            r_s1_bot_pad <= !row_lt_h;
            r_s1_wr      <= !row_gt_h && row_lt_h;
            r_s1_idx     <= r_in_col;
            r_s1_pixel   <= i_pixel;
            r_s1_emit    <= end_emit || pix_emit;
            r_s1_lsel    <= end_emit ? (r_w == WW'(1)) : col_is1;
            r_s1_rpad    <= end_emit;
            r_s1_re      <= end_emit || pix_re;
            r_s1_fe      <= end_emit ? row_gt_h : (pix_re && !row_lt_h);
        end
    end

    // read-before-write store; a write to the address being read is forwarded
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rd_up   <= r_upper_line[r_in_col];
            r_rd_mid  <= r_middle_line[r_in_col];
            r_byp     <= mem_we && (r_s1_idx == r_in_col);
            r_byp_up  <= s1_mid;
            r_byp_mid <= r_s1_pixel;
        end
        if (mem_we) begin
            r_upper_line[r_s1_idx]  <= s1_mid;
            r_middle_line[r_s1_idx] <= r_s1_pixel;
        end
    end

    assign s1_up  = r_byp ? r_byp_up  : r_rd_up;
    assign s1_mid = r_byp ? r_byp_mid : r_rd_mid;

    always_comb begin
        o_work.shift     = r_s1_shift;
        o_work.col.top   = r_s1_top_pad ? pad_px(s1_mid, r_border_mode) : s1_up;
        o_work.col.mid   = s1_mid;
        o_work.col.bot   = r_s1_bot_pad ? pad_px(s1_mid, r_border_mode) : r_s1_pixel;
        o_work.emit      = r_s1_emit;
        o_work.lsel      = r_s1_lsel;
        o_work.rpad      = r_s1_rpad;
        o_work.row_end   = r_s1_re;
        o_work.frame_end = r_s1_fe;
    end

    assign o_work_push   = s1_adv;
    assign o_border_mode = r_border_mode;

    a_ignore_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && ignore) |=> $stable(r_in_col) && $stable(r_in_row))
        else $error("ignored flush moved the raster position");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && row_gt_h) |=> (r_in_col == '0) && (r_in_row == '0))
        else $error("frame did not restart after its last code");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> r_s1_valid && $stable(r_s1_idx) && $stable(r_s1_pixel))
        else $error("stalled item lost in front stage");

endmodule

>>> rtl/lbpc_back.sv
// lbpc_back: window columns and code compare, result to the output queue
// depends on lbpc_pkg; fed by lbpc_front through a lbpc_queue
module lbpc_back
    import lbpc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_work   i_work,
    input  logic    i_work_valid,
    output logic    o_work_pop,
    input  logic    i_border_mode,
    output t_result o_res,
    output logic    o_res_push,
    input  logic    i_res_full
);

    function automatic logic [7:0] calc_code(input t_col l, input t_col c, input t_col r);
        logic [7:0] k;
        k[7] = l.top > c.mid;
        k[6] = c.top > c.mid;
        k[5] = r.top > c.mid;
        k[4] = r.mid > c.mid;
        k[3] = r.bot > c.mid;
        k[2] = c.bot > c.mid;
        k[1] = l.bot > c.mid;
        k[0] = l.mid > c.mid;
        return k;
    endfunction

    // the two newest window columns; the oldest is never read once shifted out
    t_col r_prev, r_cur;
    t_col left_col, right_col, cur_pad;

    assign o_work_pop = i_work_valid && (!i_work.emit || !i_res_full);
    assign o_res_push = o_work_pop && i_work.emit;

    // both code kinds have the newest stored column as centre
    assign cur_pad   = pad_col(r_cur, i_border_mode);
    assign left_col  = i_work.lsel ? cur_pad : r_prev;
    assign right_col = i_work.rpad ? cur_pad : i_work.col;

    always_comb begin
        o_res.code      = calc_code(left_col, r_cur, right_col);
        o_res.row_end   = i_work.row_end;
        o_res.frame_end = i_work.frame_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_cur  <= '0;
        end else if (o_work_pop && i_work.shift) begin
            r_prev <= r_cur;
            r_cur  <= i_work.col;
        end
    end

    a_fe_has_re: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && o_res.frame_end) |-> o_res.row_end)
        else $error("frame end without row end");

    // case equality: columns read from the first row of a frame may hold unknown bits
    a_window_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_work_pop && i_work.shift) |=> (r_prev === $past(r_cur)))
        else $error("window columns out of order");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_work_valid && i_work.emit && i_res_full)
            |=> (r_cur === $past(r_cur)) && (r_prev === $past(r_prev)))
        else $error("window moved while result was blocked");

endmodule

>>> bench/tb_lbp_3x3_code.sv
// tb_lbp_3x3_code: self-checking bench for the streaming 3x3 lbp code block
// tracks line stores and window in step with the dut and checks every code transaction
// depends on rtl/lbpc_pkg.sv and rtl/lbp_3x3_code.sv
module tb_lbp_3x3_code;
    timeunit 1ns;
    timeprecision 1ps;
    import lbpc_pkg::*;

    localparam int QUIET_LIMIT = 2000;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = CFG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  push       = 1'b0;
    logic                  full;
    logic                  i_action   = ACT_PIXEL;
    logic [7:0]            i_pixel    = 8'd0;
    logic                  empty;
    logic                  pop        = 1'b0;
    logic [7:0]            o_lbp_code;
    logic                  o_row_end;
    logic                  o_frame_end;

    lbp_3x3_code u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .push        (push),
        .full        (full),
        .i_action    (i_action),
        .i_pixel     (i_pixel),
        .empty       (empty),
        .pop         (pop),
        .o_lbp_code  (o_lbp_code),
        .o_row_end   (o_row_end),
        .o_frame_end (o_frame_end)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow of the block state
    logic [7:0]  upper_row_mem  [LBPC_MAX_WIDTH];
    logic [7:0]  middle_row_mem [LBPC_MAX_WIDTH];
    t_col        win_cols [3];
    int unsigned in_col, in_row, out_col, out_row;
    logic [FW_W-1:0] reg_width;
    logic [FH_W-1:0] reg_height;
    logic            reg_border;

    t_result     pending_codes [$];
    int unsigned send_gap_pct;
    int unsigned recv_stall_pct;
    int unsigned counted_items;
    int unsigned fail_count;
    int unsigned quiet_cycles;

    function automatic int unsigned cols_per_row();
        if (reg_width == '0) return 1;
        if (32'(reg_width) > LBPC_MAX_WIDTH) return LBPC_MAX_WIDTH;
        return 32'(reg_width);
    endfunction

    function automatic int unsigned rows_per_frame();
        if (reg_height == '0) return 1;
        if (32'(reg_height) > LBPC_MAX_HEIGHT) return LBPC_MAX_HEIGHT;
        return 32'(reg_height);
    endfunction

    function automatic t_col fill_col(input t_col c);
        return (reg_border == BORDER_REPLICATE) ? c : '0;
    endfunction

    function automatic logic [7:0] fill_px(input logic [7:0] v);
        return (reg_border == BORDER_REPLICATE) ? v : 8'd0;
    endfunction

    function automatic t_result code_of(input t_col l, input t_col c, input t_col r,
                                        input int unsigned w, input int unsigned h);
        t_result    res;
        logic [7:0] ctr;
        ctr = c.mid;
        res.code = {l.top > ctr, c.top > ctr, r.top > ctr, r.mid > ctr,
                    r.bot > ctr, c.bot > ctr, l.bot > ctr, l.mid > ctr};
        res.row_end   = (out_col + 1 >= w);
        res.frame_end = res.row_end && (out_row + 1 >= h);
        return res;
    endfunction

    // advance the shadow state by one accepted item, queue the code it releases
    task automatic step_window(input logic act, input logic [7:0] px);
        int unsigned w, h;
        t_col        lcol, rcol, col;
        w = cols_per_row();
        h = rows_per_frame();
        if (act == ACT_FLUSH && in_row < h) return;
        // row-end code: right neighbor column is border
        if ((in_col == 0 || in_row > h) && in_row >= 2) begin
            out_row = in_row - 2;
            out_col = w - 1;
            rcol = fill_col(win_cols[2]);
            lcol = (out_col == 0) ? fill_col(win_cols[2]) : win_cols[1];
            pending_codes.push_back(code_of(lcol, win_cols[2], rcol, w, h));
        end
        if (in_row > h) begin
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
            return;
        end
        col.mid = middle_row_mem[in_col];
        col.top = (in_row == 1) ? fill_px(col.mid) : upper_row_mem[in_col];
        col.bot = (in_row < h) ? px : fill_px(col.mid);
        if (in_row < h) begin
            upper_row_mem[in_col]  = col.mid;
            middle_row_mem[in_col] = px;
        end
        win_cols[0] = win_cols[1];
        win_cols[1] = win_cols[2];
        win_cols[2] = col;
        if (in_col >= 1 && in_row >= 1) begin
            out_row = in_row - 1;
            out_col = in_col - 1;
            lcol = (out_col == 0) ? fill_col(win_cols[1]) : win_cols[0];
            pending_codes.push_back(code_of(lcol, win_cols[1], win_cols[2], w, h));
        end
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
    endtask

    task automatic send_item(input logic act, input logic [7:0] px);
        while ($urandom_range(99) < send_gap_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push     <= 1'b1;
        i_action <= act;
        i_pixel  <= px;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        step_window(act, px);
    endtask

    // block idle: every code in, then a wait for items that release none
    task automatic wait_drained();
        push <= 1'b0;
        while (pending_codes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_frame(input logic [12:0] wdata, input logic [12:0] hdata,
                             input logic border);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_FRAME_WIDTH;
        i_cfg_data <= wdata;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_FRAME_HEIGHT;
        i_cfg_data <= hdata;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_BORDER_MODE;
        i_cfg_data <= {12'd0, border};
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        reg_width  = wdata[FW_W-1:0];
        reg_height = hdata;
        reg_border = border;
    endtask

    function automatic logic [7:0] pick_pixel(input int unsigned style, input logic [7:0] base);
        case (style)
            0: return 8'($urandom_range(255));
            1: return ($urandom_range(1) != 0) ? 8'd255 : 8'd0;
            2: return base + 8'($urandom_range(2));
            default: return base;
        endcase
    endfunction

    // flush items until the frame-end code; some are pixels, which act as flushes
    task automatic finish_frame(input int unsigned pix_pct);
        while (in_row != 0 || in_col != 0)
            send_item(($urandom_range(99) < pix_pct) ? ACT_PIXEL : ACT_FLUSH,
                      8'($urandom_range(255)));
        // stray flush after the frame is ignored
        if ($urandom_range(99) < pix_pct) send_item(ACT_FLUSH, 8'($urandom_range(255)));
    endtask

    task automatic send_frame(input logic [12:0] wdata, input logic [12:0] hdata,
                              input logic border, input int unsigned noise_pct);
        int unsigned npix;
        int unsigned style;
        logic [7:0]  base;
        wait_drained();
        set_frame(wdata, hdata, border);
        npix  = cols_per_row() * rows_per_frame();
        style = $urandom_range(3);
        base  = 8'($urandom_range(255));
        for (int unsigned k = 0; k < npix; k++) begin
            // early flush, ignored by the block
            if ($urandom_range(99) < noise_pct) send_item(ACT_FLUSH, 8'($urandom_range(255)));
            send_item(ACT_PIXEL, pick_pixel(style, base));
        end
        finish_frame(noise_pct);
        counted_items += npix + cols_per_row() + 1;
    endtask

    // reset config 640 x 480, zero border; then cut the frame short via width and height
    task automatic test_reset_defaults();
        repeat (int'(RST_FRAME_WIDTH) + 4) send_item(ACT_PIXEL, 8'($urandom_range(255)));
        wait_drained();
        set_frame(13'd5, 13'd1, BORDER_ZERO);
        finish_frame(20);
    endtask

    task automatic test_directed_cases();
        wait_drained();
        set_frame(13'd3, 13'd2, BORDER_ZERO);
        send_item(ACT_FLUSH, 8'hFF);
        send_item(ACT_PIXEL, 8'd0);
        send_item(ACT_PIXEL, 8'd255);
        send_item(ACT_PIXEL, 8'd7);
        send_item(ACT_PIXEL, 8'd7);
        send_item(ACT_PIXEL, 8'd0);
        send_item(ACT_PIXEL, 8'd255);
        send_item(ACT_FLUSH, 8'd0);
        send_item(ACT_PIXEL, 8'h80);
        send_item(ACT_FLUSH, 8'h55);
        send_item(ACT_FLUSH, 8'hAA);
        send_item(ACT_FLUSH, 8'd0);
        wait_drained();
        set_frame(13'd2, 13'd3, BORDER_REPLICATE);
        send_item(ACT_PIXEL, 8'd255);
        send_item(ACT_PIXEL, 8'd255);
        send_item(ACT_PIXEL, 8'd0);
        send_item(ACT_PIXEL, 8'd128);
        send_item(ACT_PIXEL, 8'd128);
        send_item(ACT_PIXEL, 8'd1);
        send_item(ACT_FLUSH, 8'd0);
        send_item(ACT_FLUSH, 8'hFF);
        send_item(ACT_FLUSH, 8'd0);
    endtask

    // zero width and height read as one; width takes the low 12 bits of the data
    task automatic test_register_extremes();
        send_frame(13'd0, 13'd0, BORDER_REPLICATE, 10);
        send_frame(13'h1000, 13'd1, BORDER_ZERO, 10);
        send_frame(13'h1003, 13'd2, BORDER_REPLICATE, 10);
        send_frame(13'd1, 13'd0, BORDER_ZERO, 0);
    endtask

    task automatic test_random_frames(input int unsigned n_items);
        int unsigned stop_at;
        int unsigned pick;
        logic [12:0] wd, hd;
        stop_at = counted_items + n_items;
        while (counted_items < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 4)       wd = 13'd0;
            else if (pick < 14) wd = 13'($urandom_range(48, 13));
            else                wd = 13'($urandom_range(12, 1));
            wd[12] = 1'($urandom_range(1));
            pick = $urandom_range(99);
            if (pick < 6)       hd = 13'd0;
            else if (pick < 12) hd = 13'($urandom_range(20, 9));
            else                hd = 13'($urandom_range(8, 1));
            send_frame(wd, hd, 1'($urandom_range(1)),
                       ($urandom_range(1) != 0) ? 0 : 15);
        end
    endtask

    // result side: random stalls, check each code transaction in order
    always @(posedge i_clk) begin : code_check
        t_result want;
        if (i_rst_n && pop && !empty) begin
            if (pending_codes.size() == 0) begin
                $error("unexpected transaction: lbp_code %0h row_end %0b frame_end %0b",
                       o_lbp_code, o_row_end, o_frame_end);
                fail_count++;
            end else begin
                want = pending_codes.pop_front();
                if (o_lbp_code !== want.code) begin
                    $error("lbp_code: expected %0h, got %0h", want.code, o_lbp_code);
                    fail_count++;
                end
                if (o_row_end !== want.row_end) begin
                    $error("row_end: expected %0b, got %0b", want.row_end, o_row_end);
                    fail_count++;
                end
                if (o_frame_end !== want.frame_end) begin
                    $error("frame_end: expected %0b, got %0b", want.frame_end, o_frame_end);
                    fail_count++;
                end
            end
        end
        pop <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            quiet_cycles = 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_lbp_3x3_code: errors");
            $finish;
        end else begin
            quiet_cycles++;
        end
    end

    initial begin
        foreach (upper_row_mem[k]) begin
            upper_row_mem[k]  = 8'd0;
            middle_row_mem[k] = 8'd0;
        end
        foreach (win_cols[k]) win_cols[k] = '0;
        in_col         = 0;
        in_row         = 0;
        out_col        = 0;
        out_row        = 0;
        reg_width      = RST_FRAME_WIDTH;
        reg_height     = RST_FRAME_HEIGHT;
        reg_border     = RST_BORDER_MODE;
        counted_items  = 0;
        fail_count     = 0;
        quiet_cycles   = 0;
        send_gap_pct   = 7;
        recv_stall_pct = 48;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_directed_cases();
        test_register_extremes();
        test_random_frames(370);
        send_gap_pct   = 48;
        recv_stall_pct = 7;
        test_random_frames(370);
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        test_random_frames(370);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_lbp_3x3_code: clean");
        end else begin
            $display("tb_lbp_3x3_code: errors");
        end
        $finish;
    end

endmodule
